/* rtl/md5cfb_pkg.sv */
// Package for the MD5 keystream CFB block cipher core.
// Holds the word types, the round pipeline stage type and the MD5 round tables.
// Used by md5cfb_round_cell and md5_cfb_block_cipher_core.
`default_nettype none

package md5cfb_pkg;

   localparam int unsigned Rounds = 64;
   localparam int unsigned TagWidth = 7;

   localparam logic [31:0] InitA = 32'h67452301;
   localparam logic [31:0] InitB = 32'hefcdab89;
   localparam logic [31:0] InitC = 32'h98badcfe;
   localparam logic [31:0] InitD = 32'h10325476;

   localparam logic [31:0] PadWord = 32'h0000_0080;
   localparam logic [31:0] LenWord = 32'd128;

   localparam logic [0:63][31:0] KTable = {
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [0:15][4:0] RTable = {
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef struct packed {
      logic        action;
      logic        first_block;
      logic [63:0] iv_hi;
      logic [63:0] iv_lo;
      logic [63:0] data_hi;
      logic [63:0] data_lo;
   } req_word_type;

   typedef struct packed {
      logic [63:0] out_hi;
      logic [63:0] out_lo;
   } rsp_word_type;

   typedef struct packed {
      logic                valid;
      logic [TagWidth-1:0] tag;
      logic                action;
      logic [63:0]         data_hi;
      logic [63:0]         data_lo;
      logic [3:0][31:0]    m;
      logic [31:0]         a;
      logic [31:0]         b;
      logic [31:0]         c;
      logic [31:0]         d;
   } stage_type;

   function automatic logic [31:0] bswap32(logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] r);
      logic [63:0] dbl;
      dbl = {x, x} << r;
      return dbl[63:32];
   endfunction

   function automatic stage_type round_step(stage_type s, logic [5:0] i);
      stage_type   n;
      logic [31:0] f;
      logic [3:0]  g;
      logic [31:0] mw;
      logic [31:0] t;
      n = s;
      case (i[5:4])
         2'd0: begin
            f = (s.b & s.c) | (~s.b & s.d);
            g = i[3:0];
         end
         2'd1: begin
            f = (s.d & s.b) | (~s.d & s.c);
            g = 4'(i * 6'd5 + 6'd1);
         end
         2'd2: begin
            f = s.b ^ s.c ^ s.d;
            g = 4'(i * 6'd3 + 6'd5);
         end
         default: begin
            f = s.c ^ (s.b | ~s.d);
            g = 4'(i * 6'd7);
         end
      endcase
      case (g)
         4'd0, 4'd1, 4'd2, 4'd3: mw = s.m[g[1:0]];
         4'd4: mw = PadWord;
         4'd14: mw = LenWord;
         default: mw = '0;
      endcase
      t = s.a + f + KTable[i] + mw;
      n.a = s.d;
      n.d = s.c;
      n.c = s.b;
      n.b = s.b + rotl32(t, RTable[{i[5:4], i[1:0]}]);
      return n;
   endfunction

endpackage

`default_nettype wire

/* rtl/md5cfb_round_cell.sv */
// One MD5 round cell of the keystream chain: one round, registered.
// Depends on md5cfb_pkg.
`default_nettype none

module md5cfb_round_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [5:0]            round_idx,
   input  wire md5cfb_pkg::stage_type prev_stage,
   output md5cfb_pkg::stage_type      cur_stage
);
   import md5cfb_pkg::*;

   stage_type cell_ff;
   stage_type cell_in;

   assign cell_in = round_step(prev_stage, round_idx);

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff <= cell_in;
      end
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end
   end

   assign cur_stage = cell_ff;

endmodule

`default_nettype wire

/* rtl/md5_cfb_block_cipher_core.sv */
// Top level of the MD5 keystream CFB block cipher core.
// An accepted word passes 64 round cells and one output register to its result word.
// A word that needs no earlier result (first block, or after a decrypt) enters every
// cycle while the output is not stalled. A word that follows an encrypt waits until the
// encrypt's result is written back to the feedback register, longer if the output stalls.
// Synchronous reset empties the chain and clears the feedback register to zero.
`default_nettype none

module md5_cfb_block_cipher_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire md5cfb_pkg::req_word_type req_word,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output md5cfb_pkg::rsp_word_type      rsp_word
);
   import md5cfb_pkg::*;

   stage_type           chain [0:Rounds];
   stage_type           head_stage;
   logic                advance;
   logic                accept;
   logic [63:0]         key_hi;
   logic [63:0]         key_lo;
   logic [63:0]         ks_hi;
   logic [63:0]         ks_lo;
   logic [63:0]         res_hi;
   logic [63:0]         res_lo;
   logic                write_back;

   logic [127:0]        fb_ff;
   logic [127:0]        fb_in;
   logic                pending_ff;
   logic                pending_in;
   logic [TagWidth-1:0] seq_ff;
   logic [TagWidth-1:0] seq_in;
   logic [TagWidth-1:0] last_tag_ff;
   logic [TagWidth-1:0] last_tag_in;
   logic                out_valid_ff;
   rsp_word_type        out_ff;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance || (pending_ff && !req_word.first_block);
   assign accept    = req_valid && !req_stall;

   assign key_hi = req_word.first_block ? req_word.iv_hi : fb_ff[127:64];
   assign key_lo = req_word.first_block ? req_word.iv_lo : fb_ff[63:0];

   always_comb begin
      head_stage         = '0;
      head_stage.valid   = accept;
      head_stage.tag     = seq_ff;
      head_stage.action  = req_word.action;
      head_stage.data_hi = req_word.data_hi;
      head_stage.data_lo = req_word.data_lo;
      head_stage.m[0]    = bswap32(key_hi[63:32]);
      head_stage.m[1]    = bswap32(key_hi[31:0]);
      head_stage.m[2]    = bswap32(key_lo[63:32]);
      head_stage.m[3]    = bswap32(key_lo[31:0]);
      head_stage.a       = InitA;
      head_stage.b       = InitB;
      head_stage.c       = InitC;
      head_stage.d       = InitD;
   end

   assign chain[0] = head_stage;

   for (genvar r = 0; r < Rounds; r++) begin : g_round
      md5cfb_round_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .round_idx  (6'(r)),
         .prev_stage (chain[r]),
         .cur_stage  (chain[r+1])
      );
   end

   assign ks_hi  = {bswap32(InitA + chain[Rounds].a), bswap32(InitB + chain[Rounds].b)};
   assign ks_lo  = {bswap32(InitC + chain[Rounds].c), bswap32(InitD + chain[Rounds].d)};
   assign res_hi = chain[Rounds].data_hi ^ ks_hi;
   assign res_lo = chain[Rounds].data_lo ^ ks_lo;

   assign write_back = advance && chain[Rounds].valid && !chain[Rounds].action
                       && pending_ff && (chain[Rounds].tag == last_tag_ff);

   always_comb begin
      fb_in       = fb_ff;
      pending_in  = pending_ff;
      seq_in      = seq_ff;
      last_tag_in = last_tag_ff;
      if (write_back) begin
         fb_in      = {res_hi, res_lo};
         pending_in = 1'b0;
      end
      if (accept) begin
         seq_in      = seq_ff + 1'b1;
         last_tag_in = seq_ff;
         if (req_word.action) begin
            fb_in      = {req_word.data_hi, req_word.data_lo};
            pending_in = 1'b0;
         end else begin
            pending_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff        <= '0;
         pending_ff   <= 1'b0;
         seq_ff       <= '0;
         last_tag_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fb_ff       <= fb_in;
         pending_ff  <= pending_in;
         seq_ff      <= seq_in;
         last_tag_ff <= last_tag_in;
         if (advance) begin
            out_valid_ff <= chain[Rounds].valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.out_hi <= res_hi;
         out_ff.out_lo <= res_lo;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   a_dep_wait: assert property (@(posedge clock) disable iff (reset)
      accept && pending_ff |-> req_word.first_block)
      else $error("word entered while its feedback was still in the chain");

   a_dec_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.action |=> !pending_ff)
      else $error("decrypt word left the feedback pending");

   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chain[Rounds]))
      else $error("round chain moved while the output was held");

   a_enc_pending: assert property (@(posedge clock) disable iff (reset)
      accept && !req_word.action |=> pending_ff)
      else $error("encrypt word did not mark the feedback pending");

endmodule

`default_nettype wire
